// ----- hw/rtl/sdr_pkg.sv -----
// Shared types and constants for the stick direction repeat block.
// Used by sdr_select and stick_direction_repeat; depends on nothing.
package sdr_pkg;

  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned MAG_W      = 17;  // |-32768| needs 17 bits
  localparam int unsigned SQ_W       = 31;  // 32768^2 = 2^30
  localparam int unsigned SUM_W      = 32;  // sum of two squares
  localparam int unsigned THR_W      = 15;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned ELAPSED_W  = 10;
  localparam int unsigned WAIT_W     = 18;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic [1:0]               dir_t;

  // step directions
  localparam dir_t STEP_UP    = 2'd0;
  localparam dir_t STEP_DOWN  = 2'd1;
  localparam dir_t STEP_LEFT  = 2'd2;
  localparam dir_t STEP_RIGHT = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THR_ON       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_OFF      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 2'd3;

  // configuration reset values
  localparam logic [THR_W-1:0]   THR_ON_RST       = 15'd16384;
  localparam logic [THR_W-1:0]   THR_OFF_RST      = 15'd11469;
  localparam logic [DELAY_W-1:0] FIRST_DELAY_RST  = 16'd350;
  localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST = 16'd120;

  // Winning axis of the stronger stick, ready for the threshold and state logic.
  typedef struct packed {
    logic                 active;
    logic [ELAPSED_W-1:0] elapsed;
    dir_t                 dir;
    logic [MAG_W-1:0]     mag;
  } sel_t;

  function automatic logic [MAG_W-1:0] mag_of(axis_t v);
    logic [MAG_W-1:0] ext;
    ext = {v[AXIS_W-1], v};
    mag_of = v[AXIS_W-1] ? (MAG_W'(0) - ext) : ext;
  endfunction

endpackage

// ----- hw/rtl/sdr_select.sv -----
// Two pipeline stages: axis squares, then stick and axis selection.
// Depends on sdr_pkg.
module sdr_select (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sdr_pkg::axis_t                left_x,
  input  sdr_pkg::axis_t                left_y,
  input  sdr_pkg::axis_t                right_x,
  input  sdr_pkg::axis_t                right_y,
  input  logic [sdr_pkg::ELAPSED_W-1:0] elapsed_ms,
  input  logic                          active,
  input  logic                          down_ready,
  output logic                          sel_valid,
  output sdr_pkg::sel_t                 sel
);
  import sdr_pkg::*;

  // stage 1: magnitudes and squares
  logic                 v1_r;
  logic [SQ_W-1:0]      sq_lx_r, sq_ly_r, sq_rx_r, sq_ry_r;
  logic [MAG_W-1:0]     m_lx_r, m_ly_r, m_rx_r, m_ry_r;
  logic                 n_lx_r, n_ly_r, n_rx_r, n_ry_r;
  logic                 act1_r;
  logic [ELAPSED_W-1:0] el1_r;

  // stage 2: selection result
  logic v2_r;
  sel_t sel_r;
  sel_t sel_nxt;

  logic rdy1, rdy2, take;
  logic [MAG_W-1:0]   m_lx, m_ly, m_rx, m_ry;
  logic [2*MAG_W-1:0] p_lx, p_ly, p_rx, p_ry;
  logic [SUM_W-1:0]   lsum, rsum;
  logic [MAG_W-1:0]   ax, ay;
  logic               nx, ny, left_wins, vert;

  assign rdy2     = !v2_r || down_ready;
  assign rdy1     = !v1_r || rdy2;
  assign take     = in_valid && rdy1;
  assign in_ready = rdy1;

  assign m_lx = mag_of(left_x);
  assign m_ly = mag_of(left_y);
  assign m_rx = mag_of(right_x);
  assign m_ry = mag_of(right_y);
  assign p_lx = m_lx * m_lx;
  assign p_ly = m_ly * m_ly;
  assign p_rx = m_rx * m_rx;
  assign p_ry = m_ry * m_ry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sq_lx_r <= p_lx[SQ_W-1:0];
      sq_ly_r <= p_ly[SQ_W-1:0];
      sq_rx_r <= p_rx[SQ_W-1:0];
      sq_ry_r <= p_ry[SQ_W-1:0];
      m_lx_r  <= m_lx;
      m_ly_r  <= m_ly;
      m_rx_r  <= m_rx;
      m_ry_r  <= m_ry;
      n_lx_r  <= left_x[AXIS_W-1];
      n_ly_r  <= left_y[AXIS_W-1];
      n_rx_r  <= right_x[AXIS_W-1];
      n_ry_r  <= right_y[AXIS_W-1];
      act1_r  <= active;
      el1_r   <= elapsed_ms;
    end
  end

  // left stick wins a tie; vertical axis wins a tie
  always_comb begin
    lsum      = {1'b0, sq_lx_r} + {1'b0, sq_ly_r};
    rsum      = {1'b0, sq_rx_r} + {1'b0, sq_ry_r};
    left_wins = lsum >= rsum;
    ax        = left_wins ? m_lx_r : m_rx_r;
    ay        = left_wins ? m_ly_r : m_ry_r;
    nx        = left_wins ? n_lx_r : n_rx_r;
    ny        = left_wins ? n_ly_r : n_ry_r;
    vert      = ay >= ax;
    sel_nxt.active  = act1_r;
    sel_nxt.elapsed = el1_r;
    if (vert) begin
      sel_nxt.dir = ny ? STEP_UP : STEP_DOWN;
      sel_nxt.mag = ay;
    end else begin
      sel_nxt.dir = nx ? STEP_LEFT : STEP_RIGHT;
      sel_nxt.mag = ax;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r && rdy2) begin
      sel_r <= sel_nxt;
    end
  end

  assign sel_valid = v2_r;
  assign sel       = sel_r;

endmodule

// ----- hw/rtl/stick_direction_repeat.sv -----
// Top level of the stick direction repeat block: configuration, hold/repeat state, result.
// Depends on sdr_pkg and sdr_select.
//
// Usage:
//   Input channel (in_*): one item per stick sample, both sticks as signed Q1.15
//   axes, the milliseconds since the previous sample and an active flag.
//   Result channel (out_*): exactly one item per input item, in order;
//   out_step_valid says whether a cursor step is issued, out_step_dir its
//   direction (0 up, 1 down, 2 left, 3 right), zero when no step.
//   Configuration (cfg_*): a write of cfg_data into register cfg_index at each
//   edge with cfg_wr_en high; write only while no item is in flight.
// Timing:
//   Three register stages (squares, stick/axis select, threshold and state); the
//   first loads at the accepting edge, and the item then moves on through the other two.
//   One item per cycle is sustained while out_stall is low; the hold/repeat state closes
//   its loop in the last stage, so items may follow one another in consecutive cycles.
// Reset:
//   rst_n low clears all pipeline valids, the held direction and the repeat
//   wait, and loads the default thresholds and delays.
// Stall:
//   While out_stall holds a result, the earlier stages keep filling; once they
//   are full, in_stall rises and each stage holds its item until space opens.
module stick_direction_repeat (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sdr_pkg::axis_t                 in_left_x,
  input  sdr_pkg::axis_t                 in_left_y,
  input  sdr_pkg::axis_t                 in_right_x,
  input  sdr_pkg::axis_t                 in_right_y,
  input  logic [sdr_pkg::ELAPSED_W-1:0]  in_elapsed_ms,
  input  logic                           in_active,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_step_valid,
  output sdr_pkg::dir_t                  out_step_dir,
  // configuration port
  input  logic                           cfg_wr_en,
  input  logic [sdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sdr_pkg::*;

  // configuration registers
  logic [THR_W-1:0]   thr_on_r, thr_off_r;
  logic [DELAY_W-1:0] first_delay_r, repeat_delay_r;

  // hold/repeat state
  logic                     dir_held_r, dir_held_nxt;
  dir_t                     held_dir_r, held_dir_nxt;
  logic signed [WAIT_W-1:0] wait_r, wait_nxt;

  // result register
  logic out_valid_r;
  logic step_valid_r, step_valid_nxt;
  dir_t step_dir_r, step_dir_nxt;

  logic  in_ready, out_ready, sel_valid, fire, hit;
  sel_t  sel;
  logic [THR_W-1:0]         thr;
  logic signed [WAIT_W-1:0] wait_dec;

  // Result stage accepts a new item when empty or when its item leaves.
  assign out_ready = !out_valid_r || !out_stall;
  assign fire      = sel_valid && out_ready;
  assign in_stall  = !in_ready;

  sdr_select u_select (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .left_x     (in_left_x),
    .left_y     (in_left_y),
    .right_x    (in_right_x),
    .right_y    (in_right_y),
    .elapsed_ms (in_elapsed_ms),
    .active     (in_active),
    .down_ready (out_ready),
    .sel_valid  (sel_valid),
    .sel        (sel)
  );

  // Plain register writes; the index covers exactly the four registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_on_r       <= THR_ON_RST;
      thr_off_r      <= THR_OFF_RST;
      first_delay_r  <= FIRST_DELAY_RST;
      repeat_delay_r <= REPEAT_DELAY_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_THR_ON:       thr_on_r       <= cfg_data[THR_W-1:0];
        CFG_THR_OFF:      thr_off_r      <= cfg_data[THR_W-1:0];
        CFG_FIRST_DELAY:  first_delay_r  <= cfg_data[DELAY_W-1:0];
        CFG_REPEAT_DELAY: repeat_delay_r <= cfg_data[DELAY_W-1:0];
        default:          thr_on_r       <= thr_on_r;
      endcase
    end
  end

  // Hysteresis: the release threshold (thr_off) applies while a direction is held.
  assign thr      = dir_held_r ? thr_off_r : thr_on_r;
  assign hit      = sel.mag >= {{(MAG_W-THR_W){1'b0}}, thr};
  assign wait_dec = wait_r - $signed({{(WAIT_W-ELAPSED_W){1'b0}}, sel.elapsed});

  always_comb begin
    dir_held_nxt   = dir_held_r;
    held_dir_nxt   = held_dir_r;
    wait_nxt       = wait_r;
    step_valid_nxt = 1'b0;
    if (!sel.active) begin
      // drop the held direction; keep the wait and last direction
      dir_held_nxt = 1'b0;
    end else if (!hit) begin
      dir_held_nxt = 1'b0;
    end else if (!dir_held_r || sel.dir != held_dir_r) begin
      // new direction: step at once and arm the first delay
      dir_held_nxt   = 1'b1;
      held_dir_nxt   = sel.dir;
      wait_nxt       = $signed({{(WAIT_W-DELAY_W){1'b0}}, first_delay_r});
      step_valid_nxt = 1'b1;
    end else if (wait_dec[WAIT_W-1] || wait_dec == '0) begin
      // wait expired: repeat step and reload the repeat delay
      wait_nxt       = $signed({{(WAIT_W-DELAY_W){1'b0}}, repeat_delay_r});
      step_valid_nxt = 1'b1;
    end else begin
      wait_nxt = wait_dec;
    end
    step_dir_nxt = step_valid_nxt ? sel.dir : STEP_UP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_held_r  <= 1'b0;
      held_dir_r  <= STEP_UP;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= sel_valid;
      end
      if (fire) begin
        dir_held_r <= dir_held_nxt;
        held_dir_r <= held_dir_nxt;
        wait_r     <= wait_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      step_valid_r <= step_valid_nxt;
      step_dir_r   <= step_dir_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_step_valid = step_valid_r;
  assign out_step_dir   = step_dir_r;

`ifndef SYNTHESIS
  // Input side only backs up when the result is held by the receiver.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("in_stall raised without a held result");

  // A result without a step carries direction zero.
  a_no_step_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !step_valid_r) |-> (step_dir_r == STEP_UP))
    else $error("step_dir nonzero on a result without a step");

  // Any emitted step leaves a direction held, matching the step.
  a_step_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && step_valid_nxt) |=> (dir_held_r && held_dir_r == step_dir_r))
    else $error("step emitted without holding its direction");

  // An inactive item always releases the held direction.
  a_inactive_release: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !sel.active) |=> (!dir_held_r && !step_valid_r))
    else $error("inactive item did not release the direction");

  // The repeat wait never drops below one maximal elapsed step.
  a_wait_floor: assert property (@(posedge clk) disable iff (!rst_n)
    wait_r >= -$signed({{(WAIT_W-ELAPSED_W){1'b0}}, {ELAPSED_W{1'b1}}}))
    else $error("repeat wait out of range");
`endif

endmodule

// ----- tb/sv/sdr_step_tracker_pkg.sv -----
// Step tracker for the stick direction repeat testbench: predicts the step
// each item causes and checks the results in order. Depends on sdr_pkg.
`timescale 1ns / 1ps

package sdr_step_tracker_pkg;
  import sdr_pkg::*;

  typedef struct packed {
    logic step_valid;
    dir_t step_dir;
  } step_t;

  class step_tracker;
    // register copies
    logic [THR_W-1:0]   thr_on;
    logic [THR_W-1:0]   thr_off;
    logic [DELAY_W-1:0] first_delay;
    logic [DELAY_W-1:0] repeat_delay;
    // hold/repeat state
    logic                      dir_held;
    dir_t                      held_dir;
    logic signed [WAIT_W-1:0]  wait_left;

    step_t steps_due[$];
    int    errors;

    function new();
      thr_on       = THR_ON_RST;
      thr_off      = THR_OFF_RST;
      first_delay  = FIRST_DELAY_RST;
      repeat_delay = REPEAT_DELAY_RST;
      dir_held     = 1'b0;
      held_dir     = STEP_UP;
      wait_left    = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_THR_ON:       thr_on       = data[THR_W-1:0];
        CFG_THR_OFF:      thr_off      = data[THR_W-1:0];
        CFG_FIRST_DELAY:  first_delay  = data[DELAY_W-1:0];
        CFG_REPEAT_DELAY: repeat_delay = data[DELAY_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [MAG_W-1:0] magnitude(axis_t v);
      int s;
      s = v;
      return MAG_W'(s < 0 ? -s : s);
    endfunction

    // Direction of one stick against a threshold; vertical wins a tie.
    function void stick_dir(axis_t x, axis_t y, logic [THR_W-1:0] thr,
                            output logic found, output dir_t d);
      logic [MAG_W-1:0] ax;
      logic [MAG_W-1:0] ay;
      ax = magnitude(x);
      ay = magnitude(y);
      found = !(ax < thr && ay < thr);
      if (ay >= ax) d = y[AXIS_W-1] ? STEP_UP : STEP_DOWN;
      else          d = x[AXIS_W-1] ? STEP_LEFT : STEP_RIGHT;
    endfunction

    function void note_item(axis_t lx, axis_t ly, axis_t rx, axis_t ry,
                            logic [ELAPSED_W-1:0] el, logic act);
      logic [MAG_W-1:0] alx, aly, arx, ary;
      logic [SUM_W-1:0] lsq, rsq;
      logic [THR_W-1:0] thr;
      logic             found;
      dir_t             d;
      step_t            due;
      due = '0;
      if (!act) begin
        dir_held = 1'b0;
      end else begin
        alx = magnitude(lx);
        aly = magnitude(ly);
        arx = magnitude(rx);
        ary = magnitude(ry);
        lsq = alx * alx + aly * aly;
        rsq = arx * arx + ary * ary;
        thr = dir_held ? thr_off : thr_on;
        if (lsq >= rsq) stick_dir(lx, ly, thr, found, d);
        else            stick_dir(rx, ry, thr, found, d);
        if (!found) begin
          dir_held = 1'b0;
        end else if (!dir_held || d != held_dir) begin
          dir_held       = 1'b1;
          held_dir       = d;
          wait_left      = $signed({2'b00, first_delay});
          due.step_valid = 1'b1;
          due.step_dir   = d;
        end else begin
          wait_left = wait_left - $signed({8'b0, el});
          if (wait_left <= 0) begin
            wait_left      = $signed({2'b00, repeat_delay});
            due.step_valid = 1'b1;
            due.step_dir   = d;
          end
        end
      end
      steps_due.push_back(due);
    endfunction

    function void check_step(logic got_valid, dir_t got_dir);
      step_t due;
      if (steps_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result step_valid=%0b step_dir=%0d",
                 $time, got_valid, got_dir);
        return;
      end
      due = steps_due.pop_front();
      if (got_valid !== due.step_valid) begin
        errors++;
        $display("%0t: step_valid mismatch: expected %0b, actual %0b",
                 $time, due.step_valid, got_valid);
      end
      if (got_dir !== due.step_dir) begin
        errors++;
        $display("%0t: step_dir mismatch: expected %0d, actual %0d",
                 $time, due.step_dir, got_dir);
      end
    endfunction

    function int pending();
      return steps_due.size();
    endfunction
  endclass

endpackage

// ----- tb/sv/stick_direction_repeat_test.sv -----
// Top-level testbench for stick_direction_repeat: directed and random stick
// items under random idling, checked by the step tracker.
// Depends on sdr_pkg, sdr_step_tracker_pkg and the block's RTL.
`timescale 1ns / 1ps

module stick_direction_repeat_test;
  import sdr_pkg::*;
  import sdr_step_tracker_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  logic                  in_valid;
  logic                  in_stall;
  axis_t                 in_left_x, in_left_y, in_right_x, in_right_y;
  logic [ELAPSED_W-1:0]  in_elapsed_ms;
  logic                  in_active;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_step_valid;
  dir_t                  out_step_dir;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  step_tracker steps = new();

  // when set, neither side idles
  logic no_idle = 1'b0;
  int   items_sent = 0;
  int   item_goal;

  stick_direction_repeat u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_left_x      (in_left_x),
    .in_left_y      (in_left_y),
    .in_right_x     (in_right_x),
    .in_right_y     (in_right_y),
    .in_elapsed_ms  (in_elapsed_ms),
    .in_active      (in_active),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_step_valid (out_step_valid),
    .out_step_dir   (out_step_dir),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Result side: stall about a third of the cycles, change only on the falling edge.
  always @(negedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < 32);
  end

  // Check every result accepted at a rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) steps.check_step(out_step_valid, out_step_dir);
  end

  // Offer one item; entered just after a falling edge, leaves just after one.
  // Idle first at random, then hold the payload until the block takes it.
  task automatic send_item(input axis_t lx, input axis_t ly, input axis_t rx,
                           input axis_t ry, input logic [ELAPSED_W-1:0] el,
                           input logic act);
    while (!no_idle && $urandom_range(99) < 32) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_left_x     = lx;
    in_left_y     = ly;
    in_right_x    = rx;
    in_right_y    = ry;
    in_elapsed_ms = el;
    in_active     = act;
    in_valid      = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    steps.note_item(lx, ly, rx, ry, el, act);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every expected result has come back,
  // then give the pipeline a few spare cycles.
  task automatic drain();
    in_valid = 1'b0;
    while (steps.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  // One register write; entered and left just after a falling edge.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    steps.write_reg(idx, data);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Write all four registers; the unused top bit of a threshold write is random.
  task automatic configure(input logic [THR_W-1:0] on_thr, input logic [THR_W-1:0] off_thr,
                           input logic [DELAY_W-1:0] first_ms,
                           input logic [DELAY_W-1:0] rep_ms);
    cfg_write(CFG_THR_ON, {1'($urandom_range(1)), on_thr});
    cfg_write(CFG_THR_OFF, {1'($urandom_range(1)), off_thr});
    cfg_write(CFG_FIRST_DELAY, first_ms);
    cfg_write(CFG_REPEAT_DELAY, rep_ms);
  endtask

  // Axis value from a magnitude; a magnitude of 32768 is full negative deflection.
  function automatic axis_t signed_axis(input int m, input logic neg);
    if (m >= 32768) return axis_t'(-32768);
    return neg ? axis_t'(-m) : axis_t'(m);
  endfunction

  function automatic int clamp_mag(input int m);
    if (m < 0) return 0;
    if (m > 32768) return 32768;
    return m;
  endfunction

  // Deflection levels that matter: full scale, near either threshold, anywhere, small.
  function automatic int pick_level();
    case ($urandom_range(7))
      0:       return 32768;
      1:       return 32767;
      2, 3:    return clamp_mag(int'(steps.thr_on) + int'($urandom_range(0, 4)) - 2);
      4, 5:    return clamp_mag(int'(steps.thr_off) + int'($urandom_range(0, 4)) - 2);
      6:       return $urandom_range(0, 32767);
      default: return $urandom_range(0, 2000);
    endcase
  endfunction

  // Hold one direction over a run of items with jitter, the way a thumb does;
  // now and then send a raw random item instead.
  task automatic send_gesture();
    int    n, m, mm, minor, half;
    logic  on_y, neg, use_right;
    axis_t sx, sy, ox, oy;
    logic [ELAPSED_W-1:0] el;
    logic  act;
    if ($urandom_range(9) == 0) begin
      send_item(axis_t'($urandom()), axis_t'($urandom()), axis_t'($urandom()),
                axis_t'($urandom()), ELAPSED_W'($urandom()), 1'($urandom_range(1)));
      return;
    end
    n         = $urandom_range(1, 12);
    on_y      = 1'($urandom_range(1));
    neg       = 1'($urandom_range(1));
    use_right = 1'($urandom_range(1));
    m         = pick_level();
    for (int i = 0; i < n; i++) begin
      mm = m;
      if (i > 0 && $urandom_range(2) == 0) mm = clamp_mag(m + int'($urandom_range(0, 400)) - 200);
      // minor axis: sometimes equal to the major one to hit the axis tie
      minor = ($urandom_range(7) == 0) ? mm : int'($urandom_range(0, mm));
      if (on_y) begin
        sy = signed_axis(mm, neg);
        sx = signed_axis(minor, 1'($urandom_range(1)));
      end else begin
        sx = signed_axis(mm, neg);
        sy = signed_axis(minor, 1'($urandom_range(1)));
      end
      case ($urandom_range(9))
        0: begin  // same squared magnitude on the other stick
          ox = sy;
          oy = sx;
        end
        1: begin
          ox = axis_t'($urandom());
          oy = axis_t'($urandom());
        end
        default: begin
          half = mm / 2;
          ox   = axis_t'(int'($urandom_range(0, 2 * half)) - half);
          oy   = axis_t'(int'($urandom_range(0, 2 * half)) - half);
        end
      endcase
      el  = ($urandom_range(3) == 0) ? ELAPSED_W'($urandom_range(0, 1023))
                                     : ELAPSED_W'($urandom_range(0, 120));
      act = ($urandom_range(29) != 0);
      if (use_right) send_item(ox, oy, sx, sy, el, act);
      else           send_item(sx, sy, ox, oy, el, act);
    end
  endtask

  // Register settings of each random phase, the extremes among them.
  task automatic set_phase(input int p);
    case (p)
      0: configure(THR_ON_RST, THR_OFF_RST, FIRST_DELAY_RST, REPEAT_DELAY_RST);
      1: configure(15'd32767, 15'd32767, 16'd65535, 16'd65535);
      2: configure(15'd0, 15'd0, 16'd0, 16'd0);
      // off threshold above the on threshold
      3: configure(15'd8000, 15'd20000, 16'd40, 16'd10);
      4: configure(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)),
                   16'($urandom_range(0, 600)), 16'($urandom_range(0, 300)));
      default: configure(15'($urandom_range(9000, 24000)), 15'($urandom_range(4000, 9000)),
                         16'($urandom_range(0, 500)), 16'($urandom_range(0, 200)));
    endcase
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_left_x     = '0;
    in_left_y     = '0;
    in_right_x    = '0;
    in_right_y    = '0;
    in_elapsed_ms = '0;
    in_active     = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = CFG_THR_ON;
    cfg_data      = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed items at the reset settings: on 0.5, off 0.35, delays 350 / 120.
    // inactive with every axis at full negative and the longest elapsed time
    send_item(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 10'd1023, 1'b0);
    send_item(16'sd0, 16'sd0, 16'sd0, 16'sd0, 10'd0, 1'b1);
    // full negative deflection: up at once, then wait out the first delay
    send_item(16'sd0, -16'sd32768, 16'sd0, 16'sd0, 10'd0, 1'b1);
    send_item(16'sd0, -16'sd32768, 16'sd0, 16'sd0, 10'd200, 1'b1);
    send_item(16'sd0, -16'sd32768, 16'sd0, 16'sd0, 10'd150, 1'b1);
    // held between the thresholds, long elapsed repeats; then release
    send_item(16'sd0, -16'sd12000, 16'sd0, 16'sd0, 10'd1023, 1'b1);
    send_item(16'sd0, -16'sd11000, 16'sd0, 16'sd0, 10'd10, 1'b1);
    // not held: the same deflection no longer starts a direction
    send_item(16'sd0, -16'sd12000, 16'sd0, 16'sd0, 10'd10, 1'b1);
    send_item(16'sd0, 16'sd32767, 16'sd0, 16'sd0, 10'd5, 1'b1);
    // right stick stronger: left
    send_item(16'sd100, 16'sd200, -16'sd32768, 16'sd0, 10'd5, 1'b1);
    // equal squared magnitudes pick the left stick
    send_item(16'sd20000, 16'sd0, 16'sd0, -16'sd20000, 10'd5, 1'b1);
    send_item(16'sd32767, 16'sd0, 16'sd0, 16'sd0, 10'd5, 1'b1);
    // equal axes pick the vertical one
    send_item(16'sd20000, -16'sd20000, 16'sd0, 16'sd0, 10'd5, 1'b1);
    // inactive while held clears the hold, so the next item steps again
    send_item(16'sd20000, -16'sd20000, 16'sd0, 16'sd0, 10'd5, 1'b0);
    send_item(16'sd20000, -16'sd20000, 16'sd0, 16'sd0, 10'd5, 1'b1);
    send_item(-16'sd32767, 16'sd100, 16'sd32767, -16'sd100, 10'd1023, 1'b1);
    send_item(16'sd0, 16'sd0, -16'sd16384, 16'sd0, 10'd0, 1'b1);
    send_item(16'sd0, 16'sd0, 16'sd0, 16'sd16383, 10'd1, 1'b1);
    send_item(16'sd0, 16'sd0, 16'sd0, 16'sd0, 10'd1, 1'b1);
    // exactly on the on threshold starts; one below does not
    send_item(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 10'd0, 1'b1);
    send_item(-16'sd1, -16'sd1, -16'sd1, -16'sd1, 10'd1023, 1'b1);
    send_item(16'sd0, 16'sd0, 16'sd0, 16'sd16383, 10'd0, 1'b1);

    // Random phases; reconfigure only once the pipeline is empty.
    item_goal = items_sent;
    for (int p = 0; p < 6; p++) begin
      drain();
      set_phase(p);
      no_idle   = (p == 3);
      item_goal = item_goal + 250;
      while (items_sent < item_goal) send_gesture();
    end
    no_idle  = 1'b0;
    in_valid = 1'b0;

    // Wait for the last results, then a few spare cycles for strays.
    while (steps.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (steps.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Limit the run far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
